// ===== hdl/isb_pkg.sv =====
`default_nettype none
package isb_pkg;

  // Configuration register indexes (byte address = 4 * index)
  localparam int CFG_AW = 3;
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;

  // Output queue
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
  localparam int SLOT_NUM    = 4;

  // x / 3 for x <= 765 as (x * 683) >> 11
  localparam logic [19:0] DIV3_MUL = 20'd683;

  typedef struct packed {
    logic [11:0] width;
    logic [12:0] height;
  } cfg_t;

  typedef struct packed {
    logic [11:0] row;
    logic [10:0] col;
    logic [31:0] pixel;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]              num;
    result_t [SLOT_NUM-1:0]  slot;
  } push_t;

  // 1-2-1 mix of three ARGB pixels; keep b when the new alpha is zero
  function automatic logic [31:0] mix3(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] c);
    logic [9:0]  sr;
    logic [9:0]  sg;
    logic [9:0]  sb;
    logic [9:0]  asum;
    logic [19:0] prod;
    logic [7:0]  al;
    sr   = 10'(a[23:16]) + {1'b0, b[23:16], 1'b0} + 10'(c[23:16]);
    sg   = 10'(a[15:8])  + {1'b0, b[15:8],  1'b0} + 10'(c[15:8]);
    sb   = 10'(a[7:0])   + {1'b0, b[7:0],   1'b0} + 10'(c[7:0]);
    asum = 10'(sr[9:2]) + 10'(sg[9:2]) + 10'(sb[9:2]);
    prod = 20'(asum) * DIV3_MUL;
    al   = prod[18:11];
    return (al == 8'd0) ? b : {al, sr[9:2], sg[9:2], sb[9:2]};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/inplace_separable_121_blur_core.sv =====
// Output: out_valid rises once the input transaction that finishes a result has passed
//   the row-store stage and then been written into the output queue.
// Throughput: one pixel per cycle while in_ready is high; up to four results per pixel
//   drain from an eight-entry output queue at one per cycle while out_ready is high.
// Reset: synchronous, active low; clears counters, pipeline, queue, and sets 640 x 480.
//   The row stores are not cleared; every entry is written before it is read.
`default_nettype none
module inplace_separable_121_blur_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [31:0]                 in_pixel_argb,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [11:0]                 out_row,
  output logic [10:0]                 out_column,
  output logic [31:0]                 out_pixel,
  output logic                        out_last_of_run,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [isb_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import isb_pkg::*;

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
  localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int BAW        = $clog2(BANK_DEPTH > 1 ? BANK_DEPTH : 2);

  // Stage-1 transaction: the horizontal result(s) of one pixel on their way
  // through the row stores. Delivery a is column col_a, delivery b (last
  // column only) is col_a + 1 with the original pixel.
  typedef struct packed {
    logic [RW-1:0] row;
    logic [CW-1:0] col_a;
    logic [31:0]   hv_a;
    logic [31:0]   hv_b;
    logic          has_b;
    logic          last_row;
    logic          row0;
    logic          ge2;
  } stage_t;

  typedef struct packed {
    logic [1:0]  num;
    result_t     e0;
    result_t     e1;
    logic [63:0] wdata;
  } dlv_t;

  // Row store word: final value of the row above in the upper half,
  // pending horizontal value in the lower half.
  function automatic dlv_t deliver(input logic row0, input logic ge2, input logic lrow,
                                   input logic [11:0] row_up, input logic [11:0] row_cur,
                                   input logic [10:0] col, input logic [31:0] hv,
                                   input logic [63:0] dat);
    dlv_t        d;
    logic [31:0] fv;
    fv         = mix3(dat[63:32], dat[31:0], hv);
    d.e0.row   = ge2 ? row_up : row_cur;
    d.e0.col   = col;
    d.e0.pixel = ge2 ? fv : hv;
    d.e0.last  = 1'b0;
    d.e1.row   = row_cur;
    d.e1.col   = col;
    d.e1.pixel = hv;
    d.e1.last  = 1'b0;
    if (row0) begin
      d.num = 2'd1;
    end else if (ge2) begin
      d.num = lrow ? 2'd2 : 2'd1;
    end else begin
      d.num = {1'b0, lrow};
    end
    d.wdata = {row0 ? hv : (ge2 ? fv : dat[63:32]), hv};
    return d;
  endfunction

  cfg_t           cfg;
  logic           in_acc;
  logic [CW-1:0]  lastc;
  logic [RW-1:0]  lastr;
  logic           last_col, last_row;
  logic [31:0]    hv;

  logic [CW-1:0]  col_cnt_r, col_cnt_nxt;
  logic [RW-1:0]  row_cnt_r, row_cnt_nxt;
  logic [31:0]    left_r, held_r;
  logic           s1_valid_r;
  stage_t         s1_r;

  logic [63:0]    even_rdata, odd_rdata;
  logic [BAW-1:0] even_raddr, odd_raddr;
  logic           even_we, odd_we;
  logic [BAW-1:0] even_waddr, odd_waddr;
  logic [63:0]    even_wdata, odd_wdata;

  logic [CW-1:0]  col_b;
  logic [63:0]    dat_a, dat_b;
  logic [11:0]    row_up, row_cur;
  dlv_t           dlv_a, dlv_b;
  logic [1:0]     na, nb;
  push_t          push;

  result_t           q_head;
  logic              q_not_empty;
  logic [QUEUE_PW:0] q_count;

  isb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Clamp the frame size to the supported range
  always_comb begin
    if (cfg.width < 12'd2) begin
      lastc = CW'(1);
    end else if (32'(cfg.width) > MAX_WIDTH) begin
      lastc = CW'(MAX_WIDTH - 1);
    end else begin
      lastc = CW'(cfg.width - 12'd1);
    end
    if (cfg.height == 13'd0) begin
      lastr = '0;
    end else if (32'(cfg.height) > MAX_HEIGHT) begin
      lastr = RW'(MAX_HEIGHT - 1);
    end else begin
      lastr = RW'(cfg.height - 13'd1);
    end
  end

  assign last_col = (col_cnt_r >= lastc);
  assign last_row = (row_cnt_r >= lastr);
  assign in_acc   = in_valid && in_ready;

  // Horizontal pass: column 0 keeps its original, interior columns mix with
  // the updated left neighbor and the original right neighbor.
  assign hv = (col_cnt_r == CW'(1)) ? held_r : mix3(left_r, held_r, in_pixel_argb);

  // Raster counters; a counter at or past the last index wraps
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_acc) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : row_cnt_r + 1'b1;
      end else begin
        col_cnt_nxt = col_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      left_r     <= '0;
      held_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_valid_r <= in_acc && (col_cnt_r != '0);
      if (in_acc) begin
        held_r <= in_pixel_argb;
        if (col_cnt_r != '0) begin
          left_r <= hv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.row      <= row_cnt_r;
      s1_r.col_a    <= col_cnt_r - 1'b1;
      s1_r.hv_a     <= hv;
      s1_r.hv_b     <= in_pixel_argb;
      s1_r.has_b    <= last_col;
      s1_r.last_row <= last_row;
      s1_r.row0     <= (row_cnt_r == '0);
      s1_r.ge2      <= (row_cnt_r > RW'(1));
    end
  end

  // Row stores split by column parity: columns c-1 and c always fall in
  // different banks, so each bank sees one read and one write per cycle.
  assign even_raddr = BAW'(col_cnt_r >> 1);
  assign odd_raddr  = col_cnt_r[0] ? BAW'(col_cnt_r >> 1) : BAW'((col_cnt_r - 1'b1) >> 1);

  isb_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH)) u_even_ram (
    .clk     (clk),
    .wr_en   (even_we),
    .wr_addr (even_waddr),
    .wr_data (even_wdata),
    .rd_addr (even_raddr),
    .rd_data (even_rdata)
  );

  isb_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH)) u_odd_ram (
    .clk     (clk),
    .wr_en   (odd_we),
    .wr_addr (odd_waddr),
    .wr_data (odd_wdata),
    .rd_addr (odd_raddr),
    .rd_data (odd_rdata)
  );

  // Vertical pass and result forming
  assign col_b   = s1_r.col_a + 1'b1;
  assign dat_a   = s1_r.col_a[0] ? odd_rdata : even_rdata;
  assign dat_b   = s1_r.col_a[0] ? even_rdata : odd_rdata;
  assign row_up  = 12'(s1_r.row - 1'b1);
  assign row_cur = 12'(s1_r.row);

  always_comb begin
    dlv_a = deliver(s1_r.row0, s1_r.ge2, s1_r.last_row, row_up, row_cur,
                    11'(s1_r.col_a), s1_r.hv_a, dat_a);
    dlv_b = deliver(s1_r.row0, s1_r.ge2, s1_r.last_row, row_up, row_cur,
                    11'(col_b), s1_r.hv_b, dat_b);
  end

  always_comb begin
    even_we    = s1_valid_r && (!s1_r.col_a[0] || s1_r.has_b);
    odd_we     = s1_valid_r && (s1_r.col_a[0] || s1_r.has_b);
    even_waddr = s1_r.col_a[0] ? BAW'(col_b >> 1) : BAW'(s1_r.col_a >> 1);
    odd_waddr  = s1_r.col_a[0] ? BAW'(s1_r.col_a >> 1) : BAW'(col_b >> 1);
    even_wdata = s1_r.col_a[0] ? dlv_b.wdata : dlv_a.wdata;
    odd_wdata  = s1_r.col_a[0] ? dlv_a.wdata : dlv_b.wdata;
  end

  // Pack delivery a then delivery b into consecutive queue slots; flag the
  // final one of the transaction.
  always_comb begin
    na = dlv_a.num;
    nb = s1_r.has_b ? dlv_b.num : 2'd0;
    push.num     = s1_valid_r ? (3'(na) + 3'(nb)) : 3'd0;
    push.slot[0] = (na != 2'd0) ? dlv_a.e0 : dlv_b.e0;
    push.slot[1] = (na == 2'd2) ? dlv_a.e1 : ((na == 2'd1) ? dlv_b.e0 : dlv_b.e1);
    push.slot[2] = (na == 2'd2) ? dlv_b.e0 : dlv_b.e1;
    push.slot[3] = dlv_b.e1;
    for (int k = 0; k < SLOT_NUM; k++) begin
      push.slot[k].last = ((3'(k) + 3'd1) == push.num);
    end
  end

  isb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_valid && out_ready),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  // Hold off a new pixel unless the queue can take a full burst after the
  // transaction now in the row-store stage.
  assign in_ready = ((QUEUE_PW+2)'(q_count) + (QUEUE_PW+2)'(push.num))
                    <= (QUEUE_PW+2)'(QUEUE_DEPTH - SLOT_NUM);

  assign out_valid       = q_not_empty;
  assign out_row         = q_head.row;
  assign out_column      = q_head.col;
  assign out_pixel       = q_head.pixel;
  assign out_last_of_run = q_head.last;

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_cnt_r <= CW'(MAX_WIDTH - 1))
    else $error("column counter past the widest row");

  a_col0_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && col_cnt_r == '0) |=> !s1_valid_r)
    else $error("column 0 pixel started row-store work");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (((QUEUE_PW+2)'(q_count) + (QUEUE_PW+2)'(push.num))
                    <= (QUEUE_PW+2)'(QUEUE_DEPTH)))
    else $error("output queue overflow");

endmodule
`default_nettype wire

// ===== hdl/isb_ram.sv =====
`default_nettype none
module isb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/isb_regs.sv =====
`default_nettype none
module isb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [isb_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output isb_pkg::cfg_t               cfg
);
  import isb_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= RST_IMAGE_WIDTH;
      cfg_r.height <= RST_IMAGE_HEIGHT;
    end else if (wr_en) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  cfg_r.width  <= pwdata[11:0];
        REG_IMAGE_HEIGHT: cfg_r.height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = {20'd0, cfg_r.width};
      REG_IMAGE_HEIGHT: prdata = {19'd0, cfg_r.height};
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/isb_queue.sv =====
`default_nettype none
module isb_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  isb_pkg::push_t              push,
  input  logic                        pop,
  output logic                        not_empty,
  output isb_pkg::result_t            head,
  output logic [isb_pkg::QUEUE_PW:0]  count
);
  import isb_pkg::*;

  result_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]   head_r, head_nxt;
  logic [QUEUE_PW-1:0]   tail_r, tail_nxt;
  logic [QUEUE_PW:0]     count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign head      = mem_r[head_r];
  assign count     = count_r;

  always_comb begin
    head_nxt  = head_r + QUEUE_PW'(pop);
    tail_nxt  = tail_r + QUEUE_PW'(push.num);
    count_nxt = count_r + (QUEUE_PW+1)'(push.num) - (QUEUE_PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Write up to four results at consecutive slots from the tail
  always_ff @(posedge clk) begin
    for (int k = 0; k < SLOT_NUM; k++) begin
      if (k < int'(push.num)) begin
        mem_r[tail_r + QUEUE_PW'(k)] <= push.slot[k];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QUEUE_PW+1)'(QUEUE_DEPTH))
    else $error("output queue count past depth");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.num == 3'd0) |=> (count_r == $past(count_r) - 1'b1))
    else $error("output queue count not reduced by a lone pop");

endmodule
`default_nettype wire

// ===== tb/tb_inplace_separable_121_blur_core.sv =====
`default_nettype none
module tb_inplace_separable_121_blur_core;
  timeunit 1ns;
  timeprecision 1ps;
  import isb_pkg::*;

  localparam int MAX_COLS     = 2048;
  localparam int MAX_ROWS     = 4096;
  localparam int DRAIN_CYCLES = 6;       // row-store stage and output queue plus margin
  localparam int CYCLE_LIMIT  = 300000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [31:0]         in_pixel_argb = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [11:0]         out_row;
  logic [10:0]         out_column;
  logic [31:0]         out_pixel;
  logic                out_last_of_run;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  inplace_separable_121_blur_core #(
    .MAX_WIDTH (MAX_COLS),
    .MAX_HEIGHT(MAX_ROWS)
  ) dut (.*);

  always #5 clk = ~clk;

  // Pixels waiting to be offered, and finished pixels still owed by the block
  logic [31:0] pending_pixels[$];
  result_t     blurred_ahead[$];
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Own copy of the blur state and the frame size registers
  logic [11:0] cfg_width = RST_IMAGE_WIDTH;
  logic [12:0] cfg_height = RST_IMAGE_HEIGHT;
  logic [31:0] left_hmix = '0;       // horizontal result of column c-2
  logic [31:0] held_orig = '0;       // original pixel of column c-1
  logic [31:0] top_final[MAX_COLS];  // final values of the row two above
  logic [31:0] mid_hmix[MAX_COLS];   // horizontal results of the row above
  int unsigned row_cnt = 0;
  int unsigned col_cnt = 0;
  result_t     step_out[4];
  int          step_n;
  result_t     head;

  function automatic int unsigned clamp_width(input logic [11:0] w);
    if (w < 2) return 2;
    if (w > MAX_COLS) return MAX_COLS;
    return 32'(w);
  endfunction

  function automatic int unsigned clamp_height(input logic [12:0] h);
    if (h < 1) return 1;
    if (h > MAX_ROWS) return MAX_ROWS;
    return 32'(h);
  endfunction

  // (a + 2b + c) >> 2 per color, alpha is the mean of the new colors;
  // a zero alpha leaves the center pixel untouched
  function automatic logic [31:0] mix_121(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
    logic [9:0] rs;
    logic [9:0] gs;
    logic [9:0] bs;
    logic [9:0] sum;
    logic [9:0] an;
    rs  = {2'b0, a[23:16]} + {1'b0, b[23:16], 1'b0} + {2'b0, c[23:16]};
    gs  = {2'b0, a[15:8]}  + {1'b0, b[15:8],  1'b0} + {2'b0, c[15:8]};
    bs  = {2'b0, a[7:0]}   + {1'b0, b[7:0],   1'b0} + {2'b0, c[7:0]};
    sum = {2'b0, rs[9:2]} + {2'b0, gs[9:2]} + {2'b0, bs[9:2]};
    an  = sum / 10'd3;
    if (an == 0) return b;
    return {an[7:0], rs[9:2], gs[9:2], bs[9:2]};
  endfunction

  function automatic void add_result(input int unsigned r, input int unsigned c,
                                     input logic [31:0] px);
    step_out[step_n] = '{row: 12'(r), col: 11'(c), pixel: px, last: 1'b0};
    step_n++;
  endfunction

  // A horizontal result for (r, c) is known: finish it at once in row 0, finish
  // the row above at this column from row 2 on, and the current row too when it is the last one
  function automatic void settle_column(input int unsigned r, input int unsigned c,
                                        input logic [31:0] hv, input bit last_row);
    logic [31:0] fv;
    if (c >= MAX_COLS) return;
    if (r == 0) begin
      add_result(0, c, hv);
      top_final[c] = hv;
      mid_hmix[c]  = hv;
      return;
    end
    if (r >= 2) begin
      fv = mix_121(top_final[c], mid_hmix[c], hv);
      add_result(r - 1, c, fv);
      top_final[c] = fv;
    end
    mid_hmix[c] = hv;
    if (last_row) add_result(r, c, hv);
  endfunction

  // Advance the blur by one accepted pixel and queue the pixels it finishes
  function automatic void blur_pixel_in(input logic [31:0] p);
    int unsigned w;
    int unsigned h;
    bit          last_col;
    bit          last_row;
    logic [31:0] hv;
    w = clamp_width(cfg_width);
    h = clamp_height(cfg_height);
    last_col = (col_cnt >= w - 1);
    last_row = (row_cnt >= h - 1);
    step_n = 0;
    if (col_cnt == 0) begin
      held_orig = p;
    end else begin
      hv = (col_cnt == 1) ? held_orig : mix_121(left_hmix, held_orig, p);
      settle_column(row_cnt, col_cnt - 1, hv, last_row);
      left_hmix = hv;
      held_orig = p;
      if (last_col) settle_column(row_cnt, col_cnt, p, last_row);
    end
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    for (int i = 0; i < step_n; i++) begin
      step_out[i].last = (i == step_n - 1);
      blurred_ahead.push_back(step_out[i]);
    end
  endfunction

  // Input driver: predict on each accepted transaction, hold valid and
  // payload while the block stalls, otherwise offer the next pixel or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        blur_pixel_in(in_pixel_argb);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid      <= 1'b1;
          in_pixel_argb <= pending_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted transaction with the oldest owed pixel
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (blurred_ahead.size() == 0) begin
        $error("unexpected result: row %0d column %0d pixel %h", out_row, out_column,
               out_pixel);
        fail_count++;
      end else begin
        head = blurred_ahead.pop_front();
        if (out_row !== head.row) begin
          $error("out_row: expected %0d, got %0d", head.row, out_row);
          fail_count++;
        end
        if (out_column !== head.col) begin
          $error("out_column: expected %0d, got %0d", head.col, out_column);
          fail_count++;
        end
        if (out_pixel !== head.pixel) begin
          $error("out_pixel: expected %h, got %h", head.pixel, out_pixel);
          fail_count++;
        end
        if (out_last_of_run !== head.last) begin
          $error("out_last_of_run: expected %0d, got %0d", head.last, out_last_of_run);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: drop the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic queue_pixel(input logic [31:0] p);
    pending_pixels.push_back(p);
    queued_count++;
  endtask

  // Hold the sender until every pixel is in and every owed result is out,
  // then let the pipeline settle before the next step
  task automatic wait_drained();
    while (accepted_count != queued_count || blurred_ahead.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, access cycle; the register takes the value at the edge
  // that closes the access cycle
  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_IMAGE_WIDTH) cfg_width = value[11:0];
    else cfg_height = value[12:0];
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  // Mostly small frames so rows wrap and the vertical pass runs often;
  // sometimes out-of-range sizes
  task automatic pick_frame_size();
    logic [11:0] w;
    logic [12:0] h;
    case ($urandom_range(7))
      0: w = 12'($urandom_range(1));
      1: w = 12'($urandom_range(4095, MAX_COLS));
      2: w = 12'($urandom_range(40, 10));
      default: w = 12'($urandom_range(9, 2));
    endcase
    case ($urandom_range(7))
      0: h = 13'h0;
      1: h = 13'h1FFF;
      2: h = 13'($urandom_range(20, 7));
      default: h = 13'($urandom_range(6, 1));
    endcase
    // A wider row after row 0 would read column entries this frame never
    // wrote; widen only while still in row 0
    if (clamp_width(w) > clamp_width(cfg_width) && row_cnt != 0) w = cfg_width;
    write_reg(REG_IMAGE_WIDTH, 32'(w));
    write_reg(REG_IMAGE_HEIGHT, 32'(h));
  endtask

  // Mix of full random, near-black (drives the zero-alpha keep) and extremes
  function automatic logic [31:0] random_pixel();
    case ($urandom_range(5))
      0: return {8'($urandom), 8'($urandom_range(2)), 8'($urandom_range(2)),
                 8'($urandom_range(2))};
      1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(0);

    // Width and height of zero act as 2 x 1: both columns are edges
    write_reg(REG_IMAGE_WIDTH, 32'd0);
    write_reg(REG_IMAGE_HEIGHT, 32'd0);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hFFFF_FFFF);
    wait_drained();

    // Width one acts as two; height two has no vertical pass
    write_reg(REG_IMAGE_WIDTH, 32'd1);
    write_reg(REG_IMAGE_HEIGHT, 32'd2);
    queue_pixel(32'h0000_0001);
    queue_pixel(32'hFF01_0203);
    queue_pixel(32'h8080_8080);
    queue_pixel(32'h7F7F_7F7F);
    wait_drained();

    // Oversized frame, then shrink the width mid-row so the counter
    // already sits past the last column, then shrink the height
    write_reg(REG_IMAGE_WIDTH, 32'hFFF);
    write_reg(REG_IMAGE_HEIGHT, 32'h1FFF);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hA5A5_A5A5);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 32'd3);
    queue_pixel(32'h5A5A_5A5A);
    wait_drained();
    write_reg(REG_IMAGE_HEIGHT, 32'd3);
    queue_pixel(32'h0102_0304);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'h00FF_00FF);
    queue_pixel(32'hFF00_FF00);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'h1234_5678);
    wait_drained();

    // Near-black 3 x 3 frame: horizontal and vertical mixes with zero alpha
    queue_pixel(32'h0000_0000);
    queue_pixel(32'h0000_0003);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'h0000_0400);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'h0000_0400);
    queue_pixel(32'h1200_0001);
    queue_pixel(32'h0002_0202);
    queue_pixel(32'h3400_0000);

    // Random segments; each boundary pauses the sender until the block
    // has drained, and a boundary often lands mid-frame
    for (int seg = 0; seg < 8; seg++) begin
      wait_drained();
      set_idling(seg % 4);
      pick_frame_size();
      n = $urandom_range(14, 8);
      repeat (n) queue_pixel(random_pixel());
    end
    wait_drained();
    repeat (20) @(posedge clk);

    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
